// File: src/etsr_pkg.sv
package etsr_pkg;

  // Table geometry
  localparam int CAPACITY = 64;
  localparam int ID_W     = 16;
  localparam int TRS_W    = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Operation codes
  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic              active;
    logic [ID_W-1:0]   key;
    logic [CNT_W-1:0]  count;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [ID_W-1:0]   hit_id;
    logic [TRS_W-1:0]  hit_trs;
    logic              hit_prs;
    logic [ID_W-1:0]   last_id;
    logic [TRS_W-1:0]  last_trs;
    logic              last_prs;
  } probe_t;

  // Entry write broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [ID_W-1:0]   id;
    logic [TRS_W-1:0]  trs;
    logic              prs;
  } wr_t;

endpackage

// File: src/etsr_cell.sv
module etsr_cell
  import etsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  wr_t              wr,
  input  probe_t           probe_in,
  output probe_t           probe_out
);

  logic [ID_W-1:0]  id_r;
  logic [TRS_W-1:0] trs_r;
  logic             prs_r;
  probe_t           probe_r;
  probe_t           probe_nxt;
  logic             in_use;
  logic             is_last;

  // Position checks against the count carried by the token
  assign in_use  = {1'b0, cell_idx} < probe_in.count;
  assign is_last = ({1'b0, cell_idx} + CNT_W'(1)) == probe_in.count;

  // Token update: first match wins, last valid entry is picked up
  always_comb begin
    probe_nxt = probe_in;
    if (probe_in.active && in_use && !probe_in.hit && (id_r == probe_in.key)) begin
      probe_nxt.hit     = 1'b1;
      probe_nxt.hit_idx = cell_idx;
      probe_nxt.hit_id  = id_r;
      probe_nxt.hit_trs = trs_r;
      probe_nxt.hit_prs = prs_r;
    end
    if (probe_in.active && is_last) begin
      probe_nxt.last_id  = id_r;
      probe_nxt.last_trs = trs_r;
      probe_nxt.last_prs = prs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.active <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  // Entry storage, written by address match
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      id_r  <= wr.id;
      trs_r <= wr.trs;
      prs_r <= wr.prs;
    end
  end

  assign probe_out = probe_r;

endmodule

// File: src/entity_table_swap_remove.sv
// Channel  Ports                                               Dir  Beat when
// in_      kind, entity_id, transform_id, pressable_in         in   in_valid & !in_stall
// out_     status, result_id, entry_index, result_transform,   out  out_valid & !out_stall
//          result_pressable, entry_count
//
// Add and the unused code write the result register on the input beat. Remove and lookup
// first send the search token down the chain of cells and write it when the token leaves
// the tail. The result then waits in the done state until the output register is free.
// One item is worked at a time; the next is taken once the result has moved to the
// output register, which may still be waiting on out_stall.
// Synchronous active-low reset empties the table and clears the id counter.
module entity_table_swap_remove
  import etsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_kind,
  input  logic [ID_W-1:0]  in_entity_id,
  input  logic [TRS_W-1:0] in_transform_id,
  input  logic             in_pressable_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [ID_W-1:0]  out_result_id,
  output logic [IDX_W-1:0] out_entry_index,
  output logic [TRS_W-1:0] out_result_transform,
  output logic             out_result_pressable,
  output logic [CNT_W-1:0] out_entry_count
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [IDX_W-1:0]  idx;
    logic [TRS_W-1:0]  trs;
    logic              prs;
    logic [CNT_W-1:0]  count;
  } res_t;

  state_t            state_r, state_nxt;
  kind_t             op_r, op_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ID_W-1:0]   next_id_r, next_id_nxt;
  res_t              res_r, res_nxt;
  res_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  wr_t               wr;
  probe_t            chain [CAPACITY+1];
  probe_t            tail;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Search token launched into the head of the chain
  always_comb begin
    chain[0]        = '0;
    chain[0].active = accept && ((in_kind == KIND_REMOVE) || (in_kind == KIND_LOOKUP));
    chain[0].key    = in_entity_id;
    chain[0].count  = count_r;
  end

  // Row of entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    etsr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(i)),
      .wr        (wr),
      .probe_in  (chain[i]),
      .probe_out (chain[i+1])
    );
  end

  assign tail = chain[CAPACITY];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    count_nxt     = count_r;
    next_id_nxt   = next_id_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr            = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt  = kind_t'(in_kind);
          res_nxt = '0;
          case (in_kind)
            KIND_ADD: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_nxt.status = STAT_FULL;
                res_nxt.count  = count_r;
              end else begin
                wr.en         = 1'b1;
                wr.idx        = count_r[IDX_W-1:0];
                wr.id         = next_id_r;
                wr.trs        = in_transform_id;
                wr.prs        = in_pressable_in;
                count_nxt     = count_r + CNT_W'(1);
                next_id_nxt   = next_id_r + ID_W'(1);
                res_nxt.id    = next_id_r;
                res_nxt.idx   = count_r[IDX_W-1:0];
                res_nxt.count = count_r + CNT_W'(1);
              end
              state_nxt = ST_DONE;
            end
            KIND_REMOVE, KIND_LOOKUP: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              res_nxt.count = count_r;
              state_nxt     = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (tail.active) begin
          res_nxt = '0;
          if (!tail.hit) begin
            res_nxt.status = STAT_NOT_FOUND;
            res_nxt.count  = count_r;
          end else if (op_r == KIND_REMOVE) begin
            // Swap the last valid entry into the freed slot
            wr.en         = 1'b1;
            wr.idx        = tail.hit_idx;
            wr.id         = tail.last_id;
            wr.trs        = tail.last_trs;
            wr.prs        = tail.last_prs;
            count_nxt     = count_r - CNT_W'(1);
            res_nxt.count = count_r - CNT_W'(1);
          end else begin
            res_nxt.id    = tail.hit_id;
            res_nxt.idx   = tail.hit_idx;
            res_nxt.trs   = tail.hit_trs;
            res_nxt.prs   = tail.hit_prs;
            res_nxt.count = count_r;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Move the result into the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_r.status;
  assign out_result_id        = out_r.id;
  assign out_entry_index      = out_r.idx;
  assign out_result_transform = out_r.trs;
  assign out_result_pressable = out_r.prs;
  assign out_entry_count      = out_r.count;

endmodule

// File: test/tb_top.sv
module tb_top;
  import etsr_pkg::*;

  localparam int N_ITEMS = 900;
  localparam int PHASE_LEN = 150;
  localparam int IDLE_PCT = 31;
  localparam int CALM_FROM = 8000;
  localparam int CALM_TO = 16000;
  localparam int PRINT_CAP = 40;
  // Kind code with no operation behind it
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]       kind;
    logic [ID_W-1:0]  eid;
    logic [TRS_W-1:0] trs;
    logic             prs;
  } table_op_t;

  typedef struct {
    status_t          status;
    logic [ID_W-1:0]  id;
    logic [IDX_W-1:0] idx;
    logic [TRS_W-1:0] trs;
    logic             prs;
    logic [CNT_W-1:0] cnt;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic [ID_W-1:0] in_entity_id = '0;
  logic [TRS_W-1:0] in_transform_id = '0;
  logic in_pressable_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [ID_W-1:0] out_result_id;
  logic [IDX_W-1:0] out_entry_index;
  logic [TRS_W-1:0] out_result_transform;
  logic out_result_pressable;
  logic [CNT_W-1:0] out_entry_count;

  // Shadow of the table, advanced on each accepted input beat
  logic [ID_W-1:0] shadow_id[CAPACITY];
  logic [TRS_W-1:0] shadow_trs[CAPACITY];
  logic shadow_prs[CAPACITY];
  int live_cnt = 0;
  logic [ID_W-1:0] id_ctr = '0;

  table_op_t op_backlog[$];
  table_result_t table_expect_q[$];
  table_op_t cur_op;
  int err_cnt = 0;
  int cyc = 0;
  logic calm;

  entity_table_swap_remove u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_entity_id(in_entity_id),
    .in_transform_id(in_transform_id),
    .in_pressable_in(in_pressable_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_result_id(out_result_id),
    .out_entry_index(out_entry_index),
    .out_result_transform(out_result_transform),
    .out_result_pressable(out_result_pressable),
    .out_entry_count(out_entry_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cycle count; one long window with no idling on either side
  always @(posedge clk) cyc <= cyc + 1;
  assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= PRINT_CAP)
      $display("MISMATCH %s: got %0d, want %0d (cycle %0d)", what, got, want, cyc);
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Apply one operation to the shadow table and queue the result it yields
  task automatic predict_table_op(input table_op_t op);
    table_result_t r;
    int pos;
    int last;
    int i;
    r = '{STAT_OK, '0, '0, '0, 1'b0, '0};
    pos = -1;
    // first match from position 0 upward: the loop runs downward, so the lowest hit is kept
    for (i = live_cnt - 1; i >= 0; i--)
      if (shadow_id[i] == op.eid) pos = i;
    case (op.kind)
      KIND_ADD: begin
        if (live_cnt >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          shadow_id[live_cnt] = id_ctr;
          shadow_trs[live_cnt] = op.trs;
          shadow_prs[live_cnt] = op.prs;
          r.id = id_ctr;
          r.idx = live_cnt[IDX_W-1:0];
          id_ctr = id_ctr + 1'b1;
          live_cnt++;
        end
      end
      KIND_REMOVE: begin
        if (pos < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          // last valid entry fills the hole
          last = live_cnt - 1;
          shadow_id[pos] = shadow_id[last];
          shadow_trs[pos] = shadow_trs[last];
          shadow_prs[pos] = shadow_prs[last];
          live_cnt = last;
        end
      end
      KIND_LOOKUP: begin
        if (pos < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          r.id = shadow_id[pos];
          r.idx = pos[IDX_W-1:0];
          r.trs = shadow_trs[pos];
          r.prs = shadow_prs[pos];
        end
      end
      default: ;
    endcase
    r.cnt = live_cnt[CNT_W-1:0];
    table_expect_q.push_back(r);
  endtask

  task automatic queue_op(input logic [1:0] kind, input int eid, input int trs, input logic prs);
    table_op_t op;
    op.kind = kind;
    op.eid = eid[ID_W-1:0];
    op.trs = trs[TRS_W-1:0];
    op.prs = prs;
    op_backlog.push_back(op);
  endtask

  // Random operation; phases lean towards filling, draining or a mix
  function automatic table_op_t make_op(input int phase);
    table_op_t op;
    int add_pct;
    int rem_pct;
    int roll;
    int pick;
    case (phase % 3)
      0: begin add_pct = 70; rem_pct = 12; end
      1: begin add_pct = 12; rem_pct = 62; end
      default: begin add_pct = 35; rem_pct = 30; end
    endcase
    op.eid = ID_W'($urandom_range(16'hFFFF));
    op.trs = TRS_W'($urandom_range(16'hFFFF));
    op.prs = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if (roll < add_pct) op.kind = KIND_ADD;
    else if (roll < add_pct + rem_pct) op.kind = KIND_REMOVE;
    else if (roll < 96) op.kind = KIND_LOOKUP;
    else op.kind = KIND_UNUSED;
    if (op.kind == KIND_REMOVE || op.kind == KIND_LOOKUP) begin
      pick = $urandom_range(99);
      // mostly live ids, some stale ones, the rest anything
      if (pick < 70 && live_cnt > 0)
        op.eid = shadow_id[$urandom_range(live_cnt - 1)];
      else if (pick < 85)
        op.eid = ID_W'($urandom_range(id_ctr));
    end
    return op;
  endfunction

  // Input driver: predicts on each accepted beat, then loads the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_table_op(cur_op);
      if (!in_valid || !in_stall) begin
        if (op_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_op = op_backlog.pop_front();
          in_valid <= 1'b1;
          in_kind <= cur_op.kind;
          in_entity_id <= cur_op.eid;
          in_transform_id <= cur_op.trs;
          in_pressable_in <= cur_op.prs;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (table_expect_q.size() == 0) begin
          report_mismatch("unexpected result beat, status", int'(out_status), -1);
        end else begin
          want = table_expect_q.pop_front();
          check_field("status", int'(out_status), int'(want.status));
          check_field("result_id", int'(out_result_id), int'(want.id));
          check_field("entry_index", int'(out_entry_index), int'(want.idx));
          check_field("result_transform", int'(out_result_transform), int'(want.trs));
          check_field("result_pressable", int'(out_result_pressable), int'(want.prs));
          check_field("entry_count", int'(out_entry_count), int'(want.cnt));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Stimulus and end of run
  initial begin
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: ids run 0, 1, 2 from reset
    queue_op(KIND_ADD, 16'hFFFF, 0, 1'b0);
    queue_op(KIND_ADD, 0, 16'hFFFF, 1'b1);
    queue_op(KIND_ADD, 16'h5A5A, 16'h1234, 1'b0);
    queue_op(KIND_LOOKUP, 0, 16'hFFFF, 1'b1);
    queue_op(KIND_LOOKUP, 2, 0, 1'b0);
    queue_op(KIND_LOOKUP, 1, 16'hA5A5, 1'b1);
    queue_op(KIND_LOOKUP, 16'hFFFF, 0, 1'b0);
    queue_op(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_op(KIND_UNUSED, 0, 0, 1'b0);
    queue_op(KIND_REMOVE, 16'hFFFF, 16'hFFFF, 1'b1);
    // remove from the front: last entry moves in
    queue_op(KIND_REMOVE, 0, 0, 1'b0);
    queue_op(KIND_LOOKUP, 2, 0, 1'b0);
    // remove of the last entry: only the count drops
    queue_op(KIND_REMOVE, 1, 0, 1'b0);
    queue_op(KIND_REMOVE, 1, 0, 1'b0);
    queue_op(KIND_LOOKUP, 1, 0, 1'b0);
    queue_op(KIND_REMOVE, 2, 0, 1'b0);
    // empty table
    queue_op(KIND_REMOVE, 0, 0, 1'b0);
    queue_op(KIND_LOOKUP, 0, 0, 1'b0);
    queue_op(KIND_ADD, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_op(KIND_LOOKUP, 3, 0, 1'b0);

    // random: keep the backlog short so ids track the table
    for (n = 0; n < N_ITEMS; n++) begin
      while (op_backlog.size() >= 2) @(negedge clk);
      op_backlog.push_back(make_op(n / PHASE_LEN));
    end

    while (op_backlog.size() != 0 || in_valid || table_expect_q.size() != 0)
      @(negedge clk);
    repeat (CAPACITY + 8) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
src/etsr_pkg.sv
src/etsr_cell.sv
src/entity_table_swap_remove.sv
test/tb_top.sv
